// ===== hw/rtl/twr_pkg.sv =====
// Shared types, codes and constants of the two-way ranging tag initiator.
package twr_pkg;

   localparam int NUM_TARGETS = 4;
   localparam int ANCHOR_REGS = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_TXDONE = 2'd1;
   localparam logic [1:0] ACT_FRAME  = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_POLL   = 3'd1;
   localparam logic [2:0] CMD_RANGE  = 3'd2;
   localparam logic [2:0] CMD_REPORT = 3'd3;
   localparam logic [2:0] CMD_ABORT  = 3'd4;

   localparam logic [7:0] TYPE_ACK    = 8'd1;
   localparam logic [7:0] TYPE_REPORT = 8'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_POLL  = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;

   localparam logic [2:0] CSR_ANCHOR_0 = 3'd0;
   localparam logic [2:0] CSR_ANCHOR_1 = 3'd1;
   localparam logic [2:0] CSR_ANCHOR_2 = 3'd2;
   localparam logic [2:0] CSR_ANCHOR_3 = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT  = 3'd4;
   localparam logic [2:0] CSR_GAP      = 3'd5;

   localparam logic [7:0]  ANCHOR_0_RESET = 8'd2;
   localparam logic [7:0]  ANCHOR_1_RESET = 8'd3;
   localparam logic [7:0]  ANCHOR_2_RESET = 8'd4;
   localparam logic [7:0]  ANCHOR_3_RESET = 8'd5;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd250;
   localparam logic [15:0] GAP_RESET      = 16'd500;

   typedef struct packed {
      logic [1:0]  kind;
      logic        is_ack;
      logic        is_report;
      logic [7:0]  frame_anchor;
      logic [39:0] radio_time;
      logic [31:0] range_word;
   } event_type;

   typedef struct packed {
      logic [ANCHOR_REGS-1:0][7:0] anchor_id;
      logic [15:0]                 timeout_ms;
      logic [15:0]                 gap_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/twr_if.sv =====
// Channel interfaces for request, response and register-write beats.
interface twr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  frame_type;
   logic [7:0]  frame_anchor;
   logic [39:0] radio_time;
   logic [31:0] range_word;

   modport source (output valid, action, frame_type, frame_anchor, radio_time, range_word,
                   input ready);
   modport sink (input valid, action, frame_type, frame_anchor, radio_time, range_word,
                 output ready);
endinterface

interface twr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [7:0]  target_anchor;
   logic [39:0] poll_sent_time;
   logic [39:0] ack_rx_time;
   logic [31:0] range_out;
   logic [31:0] report_number;

   modport source (output valid, command, target_anchor, poll_sent_time, ack_rx_time,
                   range_out, report_number, input ready);
   modport sink (input valid, command, target_anchor, poll_sent_time, ack_rx_time,
                 range_out, report_number, output ready);
endinterface

interface twr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/twr_front.sv =====
// Front end: accepts request beats and decodes them into queue entries.
module twr_front (
   twr_req_if.sink            req_ch,
   input  logic               queue_full,
   output logic               push,
   output twr_pkg::event_type push_data
);

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      push_data.kind         = req_ch.action;
      push_data.is_ack       = (req_ch.frame_type == twr_pkg::TYPE_ACK);
      push_data.is_report    = (req_ch.frame_type == twr_pkg::TYPE_REPORT);
      push_data.frame_anchor = req_ch.frame_anchor;
      push_data.radio_time   = req_ch.radio_time;
      push_data.range_word   = req_ch.range_word;
   end

endmodule

// ===== hw/rtl/twr_queue.sv =====
// Short event queue between the front end and the back end.
module twr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  twr_pkg::event_type push_data,
   input  logic               pop,
   output twr_pkg::event_type pop_data,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = (twr_pkg::QUEUE_DEPTH > 1) ? $clog2(twr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(twr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(twr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(twr_pkg::QUEUE_DEPTH);

   twr_pkg::event_type entry_ff [twr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == DEPTH_CNT);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/twr_back.sv =====
// Back end: ranging round state, command decision and the response register.
module twr_back (
   input  logic               clock,
   input  logic               reset,
   input  twr_pkg::cfg_type   cfg,
   input  logic               queue_empty,
   input  twr_pkg::event_type ev,
   output logic               pop,
   twr_rsp_if.source          rsp_ch
);

   localparam logic [2:0] LAST_SLOT_NEXT = 3'(twr_pkg::NUM_TARGETS);

   logic        awaiting_ff, awaiting_in;
   logic        round_open_ff, round_open_in;
   logic [1:0]  slot_ff, slot_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] gap_ff, gap_in;
   logic [1:0]  last_kind_ff, last_kind_in;
   logic [39:0] poll_tx_ff, poll_tx_in;
   logic [39:0] ack_rx_ff, ack_rx_in;
   logic [31:0] count_ff, count_in;

   logic        valid_ff;
   logic [2:0]  cmd_ff, cmd_in;
   logic [7:0]  tgt_ff, tgt_in;
   logic [39:0] pst_ff, pst_in;
   logic [39:0] art_ff, art_in;
   logic [31:0] rng_ff, rng_in;

   logic [7:0]  cur_anchor;
   logic [15:0] idle_inc;
   logic [15:0] gap_dec;
   logic [1:0]  slot_next;
   logic        expected;

   assign pop        = !queue_empty && (!valid_ff || rsp_ch.ready);
   assign cur_anchor = cfg.anchor_id[slot_ff];
   assign idle_inc   = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign gap_dec    = (gap_ff != 16'd0) ? gap_ff - 16'd1 : 16'd0;
   assign slot_next  = (({1'b0, slot_ff} + 3'd1) >= LAST_SLOT_NEXT) ? 2'd0
                                                                      : slot_ff + 2'd1;
   assign expected   = awaiting_ff ? ev.is_report : ev.is_ack;

   always_comb begin
      awaiting_in   = awaiting_ff;
      round_open_in = round_open_ff;
      slot_in       = slot_ff;
      idle_in       = idle_ff;
      gap_in        = gap_ff;
      last_kind_in  = last_kind_ff;
      poll_tx_in    = poll_tx_ff;
      ack_rx_in     = ack_rx_ff;
      count_in      = count_ff;
      cmd_in        = twr_pkg::CMD_NONE;
      tgt_in        = 8'd0;
      pst_in        = 40'd0;
      art_in        = 40'd0;
      rng_in        = 32'd0;
      case (ev.kind)
         twr_pkg::ACT_TICK: begin
            idle_in = idle_inc;
            if (round_open_ff) begin
               if (idle_inc > cfg.timeout_ms) begin
                  cmd_in        = twr_pkg::CMD_ABORT;
                  tgt_in        = cur_anchor;
                  awaiting_in   = 1'b0;
                  round_open_in = 1'b0;
                  slot_in       = slot_next;
                  gap_in        = cfg.gap_ms;
                  idle_in       = 16'd0;
               end
            end else begin
               gap_in = gap_dec;
               if (gap_dec == 16'd0) begin
                  round_open_in = 1'b1;
                  awaiting_in   = 1'b0;
                  last_kind_in  = twr_pkg::KIND_POLL;
                  idle_in       = 16'd0;
                  cmd_in        = twr_pkg::CMD_POLL;
                  tgt_in        = cur_anchor;
               end
            end
         end
         twr_pkg::ACT_TXDONE: begin
            if (last_kind_ff == twr_pkg::KIND_POLL) begin
               poll_tx_in = ev.radio_time;
            end
         end
         twr_pkg::ACT_FRAME: begin
            if (!expected) begin
               cmd_in        = twr_pkg::CMD_ABORT;
               tgt_in        = cur_anchor;
               awaiting_in   = 1'b0;
               round_open_in = 1'b0;
               slot_in       = slot_next;
               gap_in        = cfg.gap_ms;
               idle_in       = 16'd0;
            end else if (ev.frame_anchor == cur_anchor) begin
               if (!awaiting_ff) begin
                  ack_rx_in    = ev.radio_time;
                  awaiting_in  = 1'b1;
                  last_kind_in = twr_pkg::KIND_RANGE;
                  idle_in      = 16'd0;
                  cmd_in       = twr_pkg::CMD_RANGE;
                  tgt_in       = ev.frame_anchor;
                  pst_in       = poll_tx_ff;
                  art_in       = ev.radio_time;
               end else begin
                  count_in      = count_ff + 32'd1;
                  cmd_in        = twr_pkg::CMD_REPORT;
                  tgt_in        = ev.frame_anchor;
                  rng_in        = ev.range_word;
                  awaiting_in   = 1'b0;
                  round_open_in = 1'b0;
                  slot_in       = slot_next;
                  gap_in        = cfg.gap_ms;
                  idle_in       = 16'd0;
               end
            end
         end
         default: begin
            cmd_in = twr_pkg::CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff   <= 1'b0;
         round_open_ff <= 1'b0;
         slot_ff       <= 2'd0;
         idle_ff       <= 16'd0;
         gap_ff        <= 16'd0;
         last_kind_ff  <= twr_pkg::KIND_NONE;
         poll_tx_ff    <= 40'd0;
         ack_rx_ff     <= 40'd0;
         count_ff      <= 32'd0;
         valid_ff      <= 1'b0;
      end else begin
         if (pop) begin
            awaiting_ff   <= awaiting_in;
            round_open_ff <= round_open_in;
            slot_ff       <= slot_in;
            idle_ff       <= idle_in;
            gap_ff        <= gap_in;
            last_kind_ff  <= last_kind_in;
            poll_tx_ff    <= poll_tx_in;
            ack_rx_ff     <= ack_rx_in;
            count_ff      <= count_in;
            valid_ff      <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= cmd_in;
         tgt_ff <= tgt_in;
         pst_ff <= pst_in;
         art_ff <= art_in;
         rng_ff <= rng_in;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.command        = cmd_ff;
   assign rsp_ch.target_anchor  = tgt_ff;
   assign rsp_ch.poll_sent_time = pst_ff;
   assign rsp_ch.ack_rx_time    = art_ff;
   assign rsp_ch.range_out      = rng_ff;
   assign rsp_ch.report_number  = count_ff;

endmodule

// ===== hw/rtl/twr_tag_round_robin_initiator.sv =====
// Top level of the two-way ranging tag initiator with its configuration registers.
// The block takes one event beat per clock (tick, transmit done or received frame) while
// its queue has room and returns exactly one response beat per event through the queue
// entry and the response register. A two-entry queue separates request decoding from the
// round state machine, which settles one event per cycle while the response side is not
// stalled and so sets the sustained rate of one event per clock. The queue takes new
// events while a finished response waits. Registers 0 to 3 hold the anchor addresses in
// polling order, register 4 the inactivity timeout and register 5 the gap between rounds,
// both in milliseconds; they should be written only while no event is in flight.
module twr_tag_round_robin_initiator (
   input  logic       clock,
   input  logic       reset,
   twr_req_if.sink    req_ch,
   twr_rsp_if.source  rsp_ch,
   twr_csr_if.sink    csr_ch
);

   twr_pkg::cfg_type   cfg_ff;
   twr_pkg::cfg_type   cfg_in;
   twr_pkg::event_type push_data;
   twr_pkg::event_type pop_data;
   logic               push;
   logic               pop;
   logic               queue_empty;
   logic               queue_full;
   logic               csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_ch.index)
            twr_pkg::CSR_ANCHOR_0: cfg_in.anchor_id[0] = csr_ch.data[7:0];
            twr_pkg::CSR_ANCHOR_1: cfg_in.anchor_id[1] = csr_ch.data[7:0];
            twr_pkg::CSR_ANCHOR_2: cfg_in.anchor_id[2] = csr_ch.data[7:0];
            twr_pkg::CSR_ANCHOR_3: cfg_in.anchor_id[3] = csr_ch.data[7:0];
            twr_pkg::CSR_TIMEOUT:  cfg_in.timeout_ms   = csr_ch.data;
            twr_pkg::CSR_GAP:      cfg_in.gap_ms       = csr_ch.data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.anchor_id[0] <= twr_pkg::ANCHOR_0_RESET;
         cfg_ff.anchor_id[1] <= twr_pkg::ANCHOR_1_RESET;
         cfg_ff.anchor_id[2] <= twr_pkg::ANCHOR_2_RESET;
         cfg_ff.anchor_id[3] <= twr_pkg::ANCHOR_3_RESET;
         cfg_ff.timeout_ms   <= twr_pkg::TIMEOUT_RESET;
         cfg_ff.gap_ms       <= twr_pkg::GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   twr_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   twr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   twr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .ev          (pop_data),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the two-way ranging tag initiator with its own decision predictor.
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_EVENTS = 980;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_IDLE     = 40;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  frame_type;
      logic [7:0]  frame_anchor;
      logic [39:0] radio_time;
      logic [31:0] range_word;
   } radio_event_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  target;
      logic [39:0] poll_time;
      logic [39:0] ack_time;
      logic [31:0] range_val;
      logic [31:0] report_no;
   } decision_type;

   logic clock = 1'b0;
   logic reset;

   twr_req_if req_ch();
   twr_rsp_if rsp_ch();
   twr_csr_if csr_ch();

   twr_tag_round_robin_initiator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [7:0]  anchor_addr [4];
   logic [15:0] timeout_lim;
   logic [15:0] gap_len;
   logic        awaiting_rpt;
   logic        in_round;
   logic [1:0]  slot;
   logic [15:0] idle_ticks;
   logic [15:0] gap_left;
   logic [1:0]  last_tx_kind;
   logic [39:0] poll_stamp;
   logic [39:0] ack_stamp;
   logic [31:0] reports;

   decision_type owed_decisions [$];
   int           command_tally [5];
   int           events_sent;
   int           rsps_checked;
   int           failures;
   int           quiet_cycles;
   bit           steady_flow;

   function automatic logic [39:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[39:0];
   endfunction

   task automatic close_round();
      awaiting_rpt = 1'b0;
      in_round     = 1'b0;
      if (int'(slot) + 1 >= twr_pkg::NUM_TARGETS) slot = '0;
      else slot = slot + 2'd1;
      gap_left   = gap_len;
      idle_ticks = '0;
   endtask

   task automatic decide_event(input radio_event_type ev);
      decision_type d;
      logic [7:0] wanted_type;
      d = '0;
      case (ev.action)
         twr_pkg::ACT_TICK: begin
            if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
            if (in_round) begin
               if (idle_ticks > timeout_lim) begin
                  d.command = twr_pkg::CMD_ABORT;
                  d.target  = anchor_addr[slot];
                  close_round();
               end
            end else begin
               if (gap_left != 0) gap_left = gap_left - 16'd1;
               if (gap_left == 0) begin
                  in_round     = 1'b1;
                  awaiting_rpt = 1'b0;
                  last_tx_kind = twr_pkg::KIND_POLL;
                  idle_ticks   = '0;
                  d.command    = twr_pkg::CMD_POLL;
                  d.target     = anchor_addr[slot];
               end
            end
         end
         twr_pkg::ACT_TXDONE: begin
            if (last_tx_kind == twr_pkg::KIND_POLL) poll_stamp = ev.radio_time;
         end
         twr_pkg::ACT_FRAME: begin
            wanted_type = awaiting_rpt ? twr_pkg::TYPE_REPORT : twr_pkg::TYPE_ACK;
            if (ev.frame_type != wanted_type) begin
               d.command = twr_pkg::CMD_ABORT;
               d.target  = anchor_addr[slot];
               close_round();
            end else if (ev.frame_anchor == anchor_addr[slot]) begin
               if (ev.frame_type == twr_pkg::TYPE_ACK) begin
                  ack_stamp    = ev.radio_time;
                  awaiting_rpt = 1'b1;
                  last_tx_kind = twr_pkg::KIND_RANGE;
                  idle_ticks   = '0;
                  d.command    = twr_pkg::CMD_RANGE;
                  d.target     = ev.frame_anchor;
                  d.poll_time  = poll_stamp;
                  d.ack_time   = ack_stamp;
               end else begin
                  reports     = reports + 32'd1;
                  d.command   = twr_pkg::CMD_REPORT;
                  d.target    = ev.frame_anchor;
                  d.range_val = ev.range_word;
                  close_round();
               end
            end
         end
         default: begin
         end
      endcase
      d.report_no = reports;
      command_tally[d.command]++;
      owed_decisions.push_back(d);
   endtask

   task automatic post(input logic [1:0] action, input logic [7:0] ftype,
                       input logic [7:0] fanchor, input logic [39:0] stamp,
                       input logic [31:0] word);
      radio_event_type ev;
      ev = '{action, ftype, fanchor, stamp, word};
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.action       = ev.action;
      req_ch.frame_type   = ev.frame_type;
      req_ch.frame_anchor = ev.frame_anchor;
      req_ch.radio_time   = ev.radio_time;
      req_ch.range_word   = ev.range_word;
      do @(posedge clock); while (!req_ch.ready);
      decide_event(ev);
      events_sent++;
   endtask

   task automatic post_random(input logic [1:0] action, input logic [7:0] ftype,
                              input logic [7:0] fanchor);
      post(action, ftype, fanchor, rand_stamp(), $urandom);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (owed_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         twr_pkg::CSR_ANCHOR_0: anchor_addr[0] = data[7:0];
         twr_pkg::CSR_ANCHOR_1: anchor_addr[1] = data[7:0];
         twr_pkg::CSR_ANCHOR_2: anchor_addr[2] = data[7:0];
         twr_pkg::CSR_ANCHOR_3: anchor_addr[3] = data[7:0];
         twr_pkg::CSR_TIMEOUT:  timeout_lim    = data;
         twr_pkg::CSR_GAP:      gap_len        = data;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic tick_until_poll();
      while (!in_round)
         post_random(twr_pkg::ACT_TICK, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
   endtask

   task automatic test_reset_round();
      post(twr_pkg::ACT_TXDONE, 8'h00, 8'h00, 40'hFF_FFFF_FFFF, 32'h0);
      post(twr_pkg::ACT_NONE, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      post(twr_pkg::ACT_TICK, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      post(twr_pkg::ACT_TXDONE, 8'h00, 8'h00, 40'hFF_FFFF_FFFF, 32'h0);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_ACK, 8'hFF, 40'h0, 32'h0);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_ACK, twr_pkg::ANCHOR_0_RESET, 40'h0, 32'h0);
      post(twr_pkg::ACT_TXDONE, 8'h00, 8'h00, 40'h00_0012_3456, 32'h0);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_REPORT, twr_pkg::ANCHOR_1_RESET, 40'h0,
           32'hFFFF_FFFF);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_REPORT, twr_pkg::ANCHOR_0_RESET, 40'h0,
           32'hFFFF_FFFF);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_ACK, twr_pkg::ANCHOR_1_RESET,
           40'h55_5555_5555, 32'h0);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_REPORT, twr_pkg::ANCHOR_1_RESET,
           40'hAA_AAAA_AAAA, 32'h0);
      post(twr_pkg::ACT_FRAME, 8'hFF, twr_pkg::ANCHOR_2_RESET, 40'h0, 32'h0);
      post(twr_pkg::ACT_FRAME, 8'h00, twr_pkg::ANCHOR_3_RESET, 40'h0, 32'h0);
      post(twr_pkg::ACT_FRAME, twr_pkg::TYPE_REPORT, twr_pkg::ANCHOR_0_RESET, 40'h0, 32'h0);
   endtask

   task automatic test_timeout_bounds();
      settle_block();
      write_reg(twr_pkg::CSR_ANCHOR_0, 16'hFF00);
      write_reg(twr_pkg::CSR_ANCHOR_1, 16'h00FF);
      write_reg(twr_pkg::CSR_ANCHOR_2, 16'h005A);
      write_reg(twr_pkg::CSR_ANCHOR_3, 16'hA5A5);
      write_reg(twr_pkg::CSR_TIMEOUT, 16'd1);
      write_reg(twr_pkg::CSR_GAP, 16'd0);
      post_random(twr_pkg::ACT_FRAME, 8'h00, 8'h00);
      tick_until_poll();
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_FRAME, twr_pkg::TYPE_ACK, anchor_addr[slot]);
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
   endtask

   task automatic test_long_timeout();
      settle_block();
      steady_flow = 1'b1;
      write_reg(twr_pkg::CSR_TIMEOUT, 16'hFFFF);
      tick_until_poll();
      repeat (LONG_IDLE) post_random(twr_pkg::ACT_TICK, 8'h00, 8'h00);
      post_random(twr_pkg::ACT_FRAME, 8'hFF, anchor_addr[slot]);
      tick_until_poll();
      steady_flow = 1'b0;
   endtask

   task automatic linger_ticks();
      int longest;
      longest = (int'(timeout_lim) < 30) ? int'(timeout_lim) + 1 : 4;
      repeat ($urandom_range(0, longest))
         post_random(twr_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 8'h00);
   endtask

   task automatic send_round_frame(input logic [7:0] ftype);
      logic [7:0] kind;
      logic [7:0] source;
      kind   = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : ftype;
      source = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : anchor_addr[slot];
      post_random(twr_pkg::ACT_FRAME, kind, source);
   endtask

   task automatic run_round();
      tick_until_poll();
      post_random(twr_pkg::ACT_TXDONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
         post_random(twr_pkg::ACT_TXDONE, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      linger_ticks();
      send_round_frame(twr_pkg::TYPE_ACK);
      post_random(twr_pkg::ACT_TXDONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      linger_ticks();
      send_round_frame(twr_pkg::TYPE_REPORT);
   endtask

   task automatic test_random_rounds();
      int stop_at;
      int phase_end;
      stop_at = events_sent + RANDOM_EVENTS;
      for (int phase = 0; phase < 4; phase++) begin
         settle_block();
         write_reg(twr_pkg::CSR_ANCHOR_0,
                   16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)));
         write_reg(twr_pkg::CSR_ANCHOR_1,
                   16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)));
         write_reg(twr_pkg::CSR_ANCHOR_2,
                   16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)));
         write_reg(twr_pkg::CSR_ANCHOR_3,
                   16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)));
         write_reg(twr_pkg::CSR_TIMEOUT,
                   ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 24)));
         write_reg(twr_pkg::CSR_GAP, 16'($urandom_range(0, 6)));
         phase_end = stop_at - (3 - phase) * RANDOM_EVENTS / 4;
         while (events_sent < phase_end) begin
            if (events_sent > stop_at - 150) steady_flow = 1'b1;
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 4))
                  post_random(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            else
               run_round();
         end
      end
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsps_checked++;
         if (owed_decisions.size() == 0) begin
            $display("%0t: response with nothing expected, command %0d target %0h",
                     $time, rsp_ch.command, rsp_ch.target_anchor);
            failures++;
         end else begin
            want = owed_decisions.pop_front();
            check_field("command", 64'(want.command), 64'(rsp_ch.command));
            check_field("target_anchor", 64'(want.target), 64'(rsp_ch.target_anchor));
            check_field("poll_sent_time", 64'(want.poll_time), 64'(rsp_ch.poll_sent_time));
            check_field("ack_rx_time", 64'(want.ack_time), 64'(rsp_ch.ack_rx_time));
            check_field("range_out", 64'(want.range_val), 64'(rsp_ch.range_out));
            check_field("report_number", 64'(want.report_no), 64'(rsp_ch.report_number));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!steady_flow && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = twr_pkg::ACT_TICK;
      req_ch.frame_type   = '0;
      req_ch.frame_anchor = '0;
      req_ch.radio_time   = '0;
      req_ch.range_word   = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = twr_pkg::CSR_ANCHOR_0;
      csr_ch.data         = '0;
      anchor_addr[0]      = twr_pkg::ANCHOR_0_RESET;
      anchor_addr[1]      = twr_pkg::ANCHOR_1_RESET;
      anchor_addr[2]      = twr_pkg::ANCHOR_2_RESET;
      anchor_addr[3]      = twr_pkg::ANCHOR_3_RESET;
      timeout_lim         = twr_pkg::TIMEOUT_RESET;
      gap_len             = twr_pkg::GAP_RESET;
      awaiting_rpt        = 1'b0;
      in_round            = 1'b0;
      slot                = '0;
      idle_ticks          = '0;
      gap_left            = '0;
      last_tx_kind        = twr_pkg::KIND_NONE;
      poll_stamp          = '0;
      ack_stamp           = '0;
      reports             = '0;
      events_sent         = 0;
      rsps_checked        = 0;
      failures            = 0;
      quiet_cycles        = 0;
      steady_flow         = 1'b0;
      foreach (command_tally[i]) command_tally[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_round();
      test_timeout_bounds();
      test_long_timeout();
      test_random_rounds();
      settle_block();

      $display("Covered %0d events and checked %0d responses: %0d polls, %0d range frames,",
               events_sent, rsps_checked, command_tally[twr_pkg::CMD_POLL],
               command_tally[twr_pkg::CMD_RANGE]);
      $display("%0d range reports and %0d aborted rounds across several register settings.",
               command_tally[twr_pkg::CMD_REPORT], command_tally[twr_pkg::CMD_ABORT]);
      if (failures == 0 && owed_decisions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
